### sv/ltfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ltfd_pkg;

   // payload buffer geometry
   localparam int MAX_PAYLOAD = 128;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   // values per frame, up to half the payload length
   localparam int CNT_W       = $clog2(MAX_PAYLOAD / 2 + 1);

   // largest accepted length byte
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   // frame delimiters
   localparam logic [7:0] CHAR_B  = 8'h62;
   localparam logic [7:0] CHAR_Y  = 8'h79;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   // frame types that produce values
   localparam logic [7:0] KIND_INT16 = 8'd5;
   localparam logic [7:0] KIND_FLOAT = 8'd6;

   // output word layout
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 6;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_GOT_B = 3'd1,
      PH_LEN   = 3'd2,
      PH_TYPE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CR    = 3'd5,
      PH_LF    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_READ  = 3'd1,
      BK_LATCH = 3'd2,
      BK_SCALE = 3'd3,
      BK_PUSH  = 3'd4
   } back_state_type;

   // one good frame waiting to be drained
   typedef struct packed {
      logic             is_float;
      logic [CNT_W-1:0] count;
   } desc_type;

   // payload buffer write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   // queue and drain status seen by the parser
   typedef struct packed {
      logic full;
      logic busy;
   } status_type;

endpackage
`default_nettype wire

### sv/ltfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ltfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/ltfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ltfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ltfd_pkg::desc_type push_desc,
   input  wire logic               pop,
   output ltfd_pkg::desc_type      head,
   output logic                    empty,
   output logic                    full
);

   ltfd_pkg::desc_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // descriptor storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

### sv/ltfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ltfd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_byte,
   input  wire ltfd_pkg::status_type status,
   output ltfd_pkg::wr_type          wr,
   output logic                      push,
   output ltfd_pkg::desc_type        push_desc
);

   ltfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          len_ff, len_in;
   logic [7:0]          kind_ff, kind_in;
   logic [7:0]          pos_ff, pos_in;
   logic                accept;
   logic [7:0]          pos_next;
   ltfd_pkg::phase_type restart;

   // payload writes wait until the previous frame has been read out
   assign req_tready = !status.full && !((phase_ff == ltfd_pkg::PH_DATA) && status.busy);
   assign accept     = req_tvalid && req_tready;
   assign pos_next   = pos_ff + 8'd1;
   assign restart    = (req_byte == ltfd_pkg::CHAR_B) ? ltfd_pkg::PH_GOT_B : ltfd_pkg::PH_HUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ltfd_pkg::PH_HUNT;
         len_ff   <= 8'd0;
         kind_ff  <= 8'd0;
         pos_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         pos_ff   <= pos_in;
      end
   end

   // parser next state, buffer writes and frame hand-off
   always_comb begin
      phase_in       = phase_ff;
      len_in         = len_ff;
      kind_in        = kind_ff;
      pos_in         = pos_ff;
      wr.en          = 1'b0;
      wr.addr        = pos_ff[ltfd_pkg::ADDR_W-1:0];
      wr.data        = req_byte;
      push           = 1'b0;
      push_desc.is_float = (kind_ff == ltfd_pkg::KIND_FLOAT);
      push_desc.count    = '0;
      if (kind_ff == ltfd_pkg::KIND_INT16) begin
         push_desc.count = ltfd_pkg::CNT_W'(len_ff >> 1);
      end else if (kind_ff == ltfd_pkg::KIND_FLOAT) begin
         push_desc.count = ltfd_pkg::CNT_W'(len_ff >> 2);
      end
      if (accept) begin
         unique case (phase_ff)
            ltfd_pkg::PH_GOT_B: begin
               phase_in = (req_byte == ltfd_pkg::CHAR_Y) ? ltfd_pkg::PH_LEN : restart;
            end
            ltfd_pkg::PH_LEN: begin
               if (req_byte > ltfd_pkg::MAX_LEN) begin
                  phase_in = restart;
               end else begin
                  len_in   = req_byte;
                  phase_in = ltfd_pkg::PH_TYPE;
               end
            end
            ltfd_pkg::PH_TYPE: begin
               kind_in  = req_byte;
               pos_in   = 8'd0;
               phase_in = (len_ff == 8'd0) ? ltfd_pkg::PH_CR : ltfd_pkg::PH_DATA;
            end
            ltfd_pkg::PH_DATA: begin
               wr.en  = 1'b1;
               pos_in = pos_next;
               if (pos_next >= len_ff) begin
                  phase_in = ltfd_pkg::PH_CR;
               end
            end
            ltfd_pkg::PH_CR: begin
               phase_in = (req_byte == ltfd_pkg::CHAR_CR) ? ltfd_pkg::PH_LF : restart;
            end
            ltfd_pkg::PH_LF: begin
               if (req_byte == ltfd_pkg::CHAR_LF) begin
                  push     = (push_desc.count != '0);
                  phase_in = ltfd_pkg::PH_HUNT;
               end else begin
                  phase_in = restart;
               end
            end
            default: begin
               phase_in = restart;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/ltfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ltfd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ltfd_pkg::desc_type          head,
   input  wire logic                        empty,
   output logic                             pop,
   output logic                             busy,
   output logic                             rd_en,
   output logic [ltfd_pkg::ADDR_W-1:0]      rd_addr,
   input  wire logic [7:0]                  rd_data,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ltfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   ltfd_pkg::back_state_type          state_ff, state_in;
   logic                              is_float_ff, is_float_in;
   logic [ltfd_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [ltfd_pkg::CNT_W-1:0]        val_idx_ff, val_idx_in;
   logic [1:0]                        sub_ff, sub_in;
   logic [ltfd_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [31:0]                       asm_ff, asm_in;
   logic [ltfd_pkg::VALUE_W-1:0]      value_ff, value_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ltfd_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                              rsp_kind_ff, rsp_kind_in;
   logic [ltfd_pkg::INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              out_free;
   logic                              last_val;
   logic                              last_byte;
   logic [31:0]                       sext;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_val  = ((val_idx_ff + ltfd_pkg::CNT_W'(1)) == count_ff);
   assign last_byte = is_float_ff ? (sub_ff == 2'd3) : (sub_ff == 2'd1);
   assign sext      = {{16{asm_ff[31]}}, asm_ff[31:16]};
   assign busy      = (state_ff != ltfd_pkg::BK_IDLE);
   assign rd_addr   = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltfd_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_float_ff  <= is_float_in;
      count_ff     <= count_in;
      val_idx_ff   <= val_idx_in;
      sub_ff       <= sub_in;
      addr_ff      <= addr_in;
      asm_ff       <= asm_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // drain sequencer: read bytes, assemble, scale, hand to output register
   always_comb begin
      state_in     = state_ff;
      is_float_in  = is_float_ff;
      count_in     = count_ff;
      val_idx_in   = val_idx_ff;
      sub_in       = sub_ff;
      addr_in      = addr_ff;
      asm_in       = asm_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ltfd_pkg::BK_IDLE: begin
            if (!empty) begin
               pop         = 1'b1;
               is_float_in = head.is_float;
               count_in    = head.count;
               val_idx_in  = '0;
               sub_in      = 2'd0;
               addr_in     = '0;
               state_in    = ltfd_pkg::BK_READ;
            end
         end
         ltfd_pkg::BK_READ: begin
            rd_en    = 1'b1;
            state_in = ltfd_pkg::BK_LATCH;
         end
         ltfd_pkg::BK_LATCH: begin
            // bytes arrive low first, so shift in from the top
            asm_in  = {rd_data, asm_ff[31:8]};
            addr_in = addr_ff + ltfd_pkg::ADDR_W'(1);
            if (last_byte) begin
               sub_in   = 2'd0;
               state_in = ltfd_pkg::BK_SCALE;
            end else begin
               sub_in   = sub_ff + 2'd1;
               state_in = ltfd_pkg::BK_READ;
            end
         end
         ltfd_pkg::BK_SCALE: begin
            // int16 times 20 as 16s + 4s, exact in 32 bits
            if (is_float_ff) begin
               value_in = asm_ff;
            end else begin
               value_in = (sext << 4) + (sext << 2);
            end
            state_in = ltfd_pkg::BK_PUSH;
         end
         ltfd_pkg::BK_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_kind_in  = is_float_ff;
               rsp_index_in = val_idx_ff[ltfd_pkg::INDEX_W-1:0];
               rsp_last_in  = last_val;
               val_idx_in   = val_idx_ff + ltfd_pkg::CNT_W'(1);
               state_in     = last_val ? ltfd_pkg::BK_IDLE : ltfd_pkg::BK_READ;
            end
         end
         default: begin
            state_in = ltfd_pkg::BK_IDLE;
         end
      endcase
   end

   // output register drives the result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // value counter stays inside the frame while draining
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ltfd_pkg::BK_IDLE) |-> (val_idx_ff < count_ff))
      else $error("value index ran past frame count");

   // buffer data is captured only in the cycle after its read was issued
   a_read_before_latch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ltfd_pkg::BK_LATCH) |-> ($past(state_ff) == ltfd_pkg::BK_READ))
      else $error("latched buffer data without a read");

   // byte counter is rewound once a value is complete
   a_sub_rewound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ltfd_pkg::BK_SCALE) |-> (sub_ff == 2'd0))
      else $error("byte counter not rewound");

   // a frame is taken from the queue only when the drain is idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ltfd_pkg::BK_READ))
      else $error("frame popped without starting its drain");

endmodule
`default_nettype wire

### sv/length_typed_frame_deframer.sv
// Length-typed frame deframer.
// req channel: one received serial byte per word in req_tdata[7:0].
// rsp channel: one value per word; rsp_tdata holds the value in bits 31:0
// (Q15 of 20*int16, or float32 bits) and the position in the frame in bits
// 37:32; rsp_tuser is 0 for scaled int16 and 1 for float32; rsp_tlast marks
// the last value of a frame.
// Frames are 'b' 'y' length type payload CR LF; only types 5 and 6 with an
// intact trailer produce values, and lengths above 128 drop the frame.
// Throughput: header, trailer and payload bytes go in at one per cycle while
// the frame queue has room. Once a good frame is queued the drain reads the
// payload buffer through its single read port, issuing a read and then
// latching the byte for each byte of a value, then scales the value and hands
// it to the output register before it reads the next value. Payload bytes of
// the next frame stall until that drain is done.
// Reset clears the parser to hunting, empties the frame queue and drops any
// value not yet delivered. When rsp_tready is low the value holds in the
// output register and the drain waits; the parser keeps taking header bytes.
`timescale 1ns / 1ps
`default_nettype none
module length_typed_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // sample_value, channel_index, zero pad
   output logic             rsp_tuser,   // sample_kind
   output logic             rsp_tlast    // frame_last
);

   ltfd_pkg::wr_type             wr;
   ltfd_pkg::status_type         status;
   ltfd_pkg::desc_type           push_desc;
   ltfd_pkg::desc_type           head;
   logic                         push;
   logic                         pop;
   logic                         empty;
   logic                         full;
   logic                         back_busy;
   logic                         rd_en;
   logic [ltfd_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                   rd_data;

   // buffer is in use while a frame waits or drains
   assign status.full = full;
   assign status.busy = back_busy || !empty;

   ltfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .status     (status),
      .wr         (wr),
      .push       (push),
      .push_desc  (push_desc)
   );

   ltfd_ram #(
      .WIDTH (8),
      .DEPTH (ltfd_pkg::MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ltfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   ltfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .busy       (back_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### tb/sv/ltfd_checker.sv
`timescale 1ns / 1ps
module ltfd_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,   // rx_byte
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [ltfd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // sample_value, channel_index, pad
   input  wire logic                           rsp_tuser,   // sample_kind
   input  wire logic                           rsp_tlast,   // frame_last
   output int                                  mismatch_count,
   output int                                  samples_pending
);

   typedef struct packed {
      logic [ltfd_pkg::VALUE_W-1:0] value;
      logic [ltfd_pkg::INDEX_W-1:0] index;
      logic                         is_float;
      logic                         last;
   } sample_type;

   sample_type expected_samples [$];
   int         errors = 0;

   // shadow copy of the parser
   ltfd_pkg::phase_type phase;
   logic [7:0]          frame_len;
   logic [7:0]          frame_type;
   logic [7:0]          fill_pos;
   logic [7:0]          payload [ltfd_pkg::MAX_PAYLOAD];

   // a failed match starts a new header when the byte is 'b'
   function automatic ltfd_pkg::phase_type hunt_from(input logic [7:0] rx);
      return (rx == ltfd_pkg::CHAR_B) ? ltfd_pkg::PH_GOT_B : ltfd_pkg::PH_HUNT;
   endfunction

   // queue the values that a frame with a good trailer yields
   task automatic unpack_frame();
      int                 count;
      logic               is_float;
      logic signed [15:0] half;
      sample_type         s;
      is_float = 1'b0;
      count    = 0;
      if (frame_type == ltfd_pkg::KIND_INT16) begin
         count = frame_len / 2;
      end else if (frame_type == ltfd_pkg::KIND_FLOAT) begin
         count    = frame_len / 4;
         is_float = 1'b1;
      end
      for (int k = 0; k < count; k++) begin
         if (is_float) begin
            s.value = {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
         end else begin
            half    = {payload[2*k+1], payload[2*k]};
            // q15 of 20*s is just the integer product
            s.value = half * 20;
         end
         s.index    = ltfd_pkg::INDEX_W'(k);
         s.is_float = is_float;
         s.last     = (k == count - 1);
         expected_samples.push_back(s);
      end
   endtask

   // advance the parser by one received byte
   task automatic parse_byte(input logic [7:0] rx);
      case (phase)
         ltfd_pkg::PH_GOT_B: phase = (rx == ltfd_pkg::CHAR_Y) ? ltfd_pkg::PH_LEN : hunt_from(rx);
         ltfd_pkg::PH_LEN: begin
            if (rx > ltfd_pkg::MAX_LEN) begin
               phase = hunt_from(rx);
            end else begin
               frame_len = rx;
               phase     = ltfd_pkg::PH_TYPE;
            end
         end
         ltfd_pkg::PH_TYPE: begin
            frame_type = rx;
            fill_pos   = 8'd0;
            phase      = (frame_len == 8'd0) ? ltfd_pkg::PH_CR : ltfd_pkg::PH_DATA;
         end
         ltfd_pkg::PH_DATA: begin
            if (fill_pos < ltfd_pkg::MAX_PAYLOAD) payload[fill_pos[ltfd_pkg::ADDR_W-1:0]] = rx;
            fill_pos = fill_pos + 8'd1;
            if (fill_pos >= frame_len) phase = ltfd_pkg::PH_CR;
         end
         ltfd_pkg::PH_CR: phase = (rx == ltfd_pkg::CHAR_CR) ? ltfd_pkg::PH_LF : hunt_from(rx);
         ltfd_pkg::PH_LF: begin
            if (rx == ltfd_pkg::CHAR_LF) begin
               unpack_frame();
               phase = ltfd_pkg::PH_HUNT;
            end else begin
               phase = hunt_from(rx);
            end
         end
         default: phase = hunt_from(rx);
      endcase
   endtask

   // compare one delivered word with the oldest expected value
   task automatic check_sample();
      sample_type want;
      if (expected_samples.size() == 0) begin
         $display("%0t unexpected word: expected none, actual value %h index %0d kind %0b last %0b",
                  $time, rsp_tdata[31:0], rsp_tdata[37:32], rsp_tuser, rsp_tlast);
         errors++;
      end else begin
         want = expected_samples.pop_front();
         if (rsp_tdata[31:0] !== want.value) begin
            $display("%0t sample_value: expected %h actual %h", $time, want.value,
                     rsp_tdata[31:0]);
            errors++;
         end
         if (rsp_tdata[37:32] !== want.index) begin
            $display("%0t channel_index: expected %0d actual %0d", $time, want.index,
                     rsp_tdata[37:32]);
            errors++;
         end
         if (rsp_tdata[39:38] !== 2'b00) begin
            $display("%0t tdata pad: expected 0 actual %b", $time, rsp_tdata[39:38]);
            errors++;
         end
         if (rsp_tuser !== want.is_float) begin
            $display("%0t sample_kind: expected %0b actual %b", $time, want.is_float,
                     rsp_tuser);
            errors++;
         end
         if (rsp_tlast !== want.last) begin
            $display("%0t frame_last: expected %0b actual %b", $time, want.last, rsp_tlast);
            errors++;
         end
      end
   endtask

   // watch both channels, results first since none can stem from this byte
   always @(posedge clock) begin
      if (reset) begin
         phase      = ltfd_pkg::PH_HUNT;
         frame_len  = 8'd0;
         frame_type = 8'd0;
         fill_pos   = 8'd0;
         expected_samples.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_sample();
         if (req_tvalid && req_tready) parse_byte(req_tdata);
      end
      mismatch_count  <= errors;
      samples_pending <= expected_samples.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 6;
   // a float frame drains value by value and each value may sit out a
   // long random receiver stall; idle gaps of the sender are much shorter
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;
   // random bytes after the opening sequence, split over the idling profiles
   localparam int RANDOM_BYTES  = 130;

   localparam logic [7:0] KIND_OTHER = 8'd7;

   typedef enum logic [2:0] {
      FRAME_GOOD,
      BREAK_Y,
      BREAK_LEN,
      BREAK_CR,
      BREAK_LF
   } frame_fault_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic [7:0]                      req_tdata  = 8'h00;
   logic                            rsp_tready = 1'b0;
   logic                            req_tready;
   logic                            rsp_tvalid;
   logic [ltfd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   int mismatch_count;
   int samples_pending;
   int send_idle_pct = 33;
   int recv_idle_pct = 50;
   int quiet_cycles  = 0;
   int sent_bytes    = 0;

   logic [7:0] opening_bytes [$];

   length_typed_frame_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ltfd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .samples_pending (samples_pending)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles without any word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // one byte on the req channel, valid stays high into the next byte
   task automatic send_rx_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sent_bytes++;
   endtask

   // hold the sender until every expected value has come out
   task automatic wait_for_values();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (samples_pending != 0);
   endtask

   // full frame with random payload and an optional damaged byte
   task automatic send_frame(input int len, input logic [7:0] kind,
                             input frame_fault_type fault);
      logic [7:0] bad;
      bad = 8'($urandom);
      send_rx_byte(ltfd_pkg::CHAR_B);
      send_rx_byte((fault == BREAK_Y) ?
                   ((bad == ltfd_pkg::CHAR_Y) ? ltfd_pkg::CHAR_B : bad) : ltfd_pkg::CHAR_Y);
      send_rx_byte((fault == BREAK_LEN) ?
                   8'($urandom_range(ltfd_pkg::MAX_PAYLOAD + 1, 255)) : 8'(len));
      send_rx_byte(kind);
      repeat (len) send_rx_byte(8'($urandom));
      send_rx_byte((fault == BREAK_CR) ?
                   ((bad == ltfd_pkg::CHAR_CR) ? ltfd_pkg::CHAR_B : bad) : ltfd_pkg::CHAR_CR);
      send_rx_byte((fault == BREAK_LF) ?
                   ((bad == ltfd_pkg::CHAR_LF) ? ltfd_pkg::CHAR_B : bad) : ltfd_pkg::CHAR_LF);
   endtask

   // mostly good frames, some damaged ones and some line noise
   task automatic random_traffic();
      int         pick;
      int         len;
      logic [7:0] kind;
      pick = $urandom_range(99);
      if (pick >= 85) begin
         repeat ($urandom_range(1, 6))
            send_rx_byte(($urandom_range(3) == 0) ? ltfd_pkg::CHAR_B : 8'($urandom));
         return;
      end
      len = ($urandom_range(19) == 0) ? $urandom_range(13, 32) : $urandom_range(0, 12);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: kind = ltfd_pkg::KIND_INT16;
         5, 6, 7:       kind = ltfd_pkg::KIND_FLOAT;
         default:       kind = 8'($urandom);
      endcase
      send_frame(len, kind,
                 (pick < 70) ? FRAME_GOOD : frame_fault_type'(3'($urandom_range(1, 4))));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // int16 extremes after a repeated 'b', oversized length then a float
      // frame with a leftover byte, short float frame with a bad lf that
      // restarts the header, and an empty frame of another type
      opening_bytes = '{
         ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_Y, 8'd4, ltfd_pkg::KIND_INT16,
         8'h00, 8'h80, 8'hff, 8'h7f, ltfd_pkg::CHAR_CR, ltfd_pkg::CHAR_LF,
         ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_Y, ltfd_pkg::MAX_LEN + 8'd1,
         ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_Y, 8'd5, ltfd_pkg::KIND_FLOAT,
         8'h00, 8'h00, 8'h80, 8'hff, 8'h01, ltfd_pkg::CHAR_CR, ltfd_pkg::CHAR_LF,
         ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_Y, 8'd3, ltfd_pkg::KIND_FLOAT,
         8'h55, 8'haa, 8'h01, ltfd_pkg::CHAR_CR,
         ltfd_pkg::CHAR_B, ltfd_pkg::CHAR_Y, 8'd0, KIND_OTHER,
         ltfd_pkg::CHAR_CR, ltfd_pkg::CHAR_LF
      };
      foreach (opening_bytes[i]) send_rx_byte(opening_bytes[i]);
      wait_for_values();

      // three idling profiles, each ending on a drained pipe
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 33 : (p == 1) ? 50 : 0;
         recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 33 : 0;
         while (sent_bytes < opening_bytes.size() + (p + 1) * RANDOM_BYTES / 3)
            random_traffic();
         wait_for_values();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && samples_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
